@@ src/fdmd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdmd_pkg
// Types, register codes and constants used by the frame difference
// motion detector; the generic reference bitmap RAM does not import them.
// ----------------------------------------------------------------------------
package fdmd_pkg;

	localparam int FRAME_PIXELS = 1048576;
	localparam int IDX_W        = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

	localparam int LEVEL_W = 8;
	localparam int TOTAL_W = 31;
	localparam int PROD_W  = 24;
	localparam int SUM_W   = 25;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX       = {TOTAL_W{1'b1}};
	localparam logic [TOTAL_W-1:0] MISMATCH_WEIGHT = TOTAL_W'(255);

	// luma weights in unsigned 0.16 fixed point
	localparam logic [15:0] W_RED   = 16'd19589;
	localparam logic [15:0] W_GREEN = 16'd38470;
	localparam logic [15:0] W_BLUE  = 16'd7471;

	localparam logic [LEVEL_W-1:0] LEVEL_RESET = 8'd50;

	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BINARIZE_LEVEL = 2'd0,
		REG_DIFF_LIMIT     = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_pixel;
	} pixel_t;

	typedef struct packed {
		logic               detected;
		logic [TOTAL_W-1:0] diff_total;
		logic               reference_set;
	} result_t;

endpackage
`default_nettype wire

@@ src/fdmd_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdmd_ram
// Generic simple dual port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module fdmd_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ src/frame_difference_motion_detector.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_difference_motion_detector
// Binarizes RGB pixels against a level, compares each bit with the reference
// bitmap in RAM and totals the mismatches; reports once per frame.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  pix     | in        | pix_valid/pix_stall | pixel_t  (red, green, blue, last)
//  res     | out       | res_valid/res_stall | result_t (one per frame)
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One pixel per cycle while pix_stall is low. Accept registers the luma products and reads the
// reference bit; stage 1 binarizes, compares and writes the bit back; stage 2
// accumulates. The result register loads when the last pixel leaves stage 2.
// pix_stall rises only while a frame result waits behind an untaken result.
// Reset clears counters and totals; the bitmap RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module frame_difference_motion_detector
	import fdmd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 pix_valid,
	output logic                      pix_stall,
	input  wire pixel_t               pix,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output result_t                   res,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [TOTAL_W-1:0]   cfg_data
);

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_PIXELS - 1);

	logic [LEVEL_W-1:0] level_q;
	logic [TOTAL_W-1:0] limit_q;

	logic [IDX_W-1:0]   idx_q;
	logic [TOTAL_W-1:0] total_q;
	logic               ref_valid_q;

	logic               valid_s1, last_s1, fwd_hit_s1, fwd_bit_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [PROD_W-1:0]  prod_r_s1, prod_g_s1, prod_b_s1;

	logic               valid_s2, last_s2, mismatch_s2;

	logic               res_valid_q;
	result_t            res_q;

	logic               adv, accept;
	logic               ram_bit;
	logic [SUM_W-1:0]   gray_sum;
	logic [7:0]         gray;
	logic               pix_bit, ref_bit;
	logic               add_ok;
	logic [TOTAL_W-1:0] total_sat, total_new;

	// advance unless a frame result is blocked by an untaken result
	assign adv       = !(valid_s2 && last_s2) || !res_valid_q || !res_stall;
	assign pix_stall = !adv;
	assign accept    = pix_valid && adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LEVEL_RESET;
			limit_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BINARIZE_LEVEL: level_q <= cfg_data[LEVEL_W-1:0];
				REG_DIFF_LIMIT:     limit_q <= cfg_data;
				default:            ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (accept) begin
			if (pix.last_pixel || idx_q == IDX_LAST) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	fdmd_ram #(
		.WIDTH(1),
		.DEPTH(FRAME_PIXELS),
		.AW   (IDX_W)
	) u_ref_ram (
		.clk    (clk),
		.wr_en  (valid_s1),
		.wr_addr(idx_s1),
		.wr_data(pix_bit),
		.rd_en  (accept),
		.rd_addr(idx_q),
		.rd_data(ram_bit)
	);

	// stage 1: binarize, compare, write back
	assign gray_sum = SUM_W'(prod_r_s1) + SUM_W'(prod_g_s1) + SUM_W'(prod_b_s1);
	assign gray     = gray_sum[23:16];
	assign pix_bit  = gray > level_q;
	assign ref_bit  = fwd_hit_s1 ? fwd_bit_s1 : ram_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1    <= pix.last_pixel;
			idx_s1     <= idx_q;
			prod_r_s1  <= PROD_W'(pix.red)   * PROD_W'(W_RED);
			prod_g_s1  <= PROD_W'(pix.green) * PROD_W'(W_GREEN);
			prod_b_s1  <= PROD_W'(pix.blue)  * PROD_W'(W_BLUE);
			// the write in flight this cycle is not yet visible to the read
			fwd_hit_s1 <= valid_s1 && (idx_s1 == idx_q);
			fwd_bit_s1 <= pix_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			last_s2     <= last_s1;
			mismatch_s2 <= pix_bit != ref_bit;
		end
	end

	// stage 2: accumulate with early exit and saturation
	assign add_ok    = ref_valid_q && (total_q <= limit_q) && mismatch_s2;
	assign total_sat = (total_q > TOTAL_MAX - MISMATCH_WEIGHT) ? TOTAL_MAX
	                   : total_q + MISMATCH_WEIGHT;
	assign total_new = add_ok ? total_sat : total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			ref_valid_q <= 1'b0;
		end else if (adv && valid_s2) begin
			if (last_s2) begin
				total_q     <= '0;
				ref_valid_q <= 1'b1;
			end else begin
				total_q <= total_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && valid_s2 && last_s2) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2 && last_s2) begin
			res_q.detected      <= ref_valid_q && (total_new > limit_q);
			res_q.diff_total    <= ref_valid_q ? total_new : '0;
			res_q.reference_set <= !ref_valid_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire
